// File: rtl/mavp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavp_pkg: shared types and constants
// widths, register indexes, sequencer states and saturation helpers for the
// moving average velocity profiler
// ----------------------------------------------------------------------------
package mavp_pkg;

   // boxcar history depth, also the upper clamp of the window length
   localparam int MAX_WINDOW = 256;
   localparam int HIST_AW    = $clog2(MAX_WINDOW);
   // tick counter holds up to MAX_WINDOW + 2 before clamping
   localparam int TICK_W     = $clog2(MAX_WINDOW + 3);

   localparam int WIN_W      = 9;
   localparam int DATA_W     = 32;
   localparam int ACC_W      = 48;
   localparam int CSR_AW     = 2;
   localparam int DIV_CNT_W  = $clog2(DATA_W);

   typedef enum logic [CSR_AW-1:0] {
      CSR_WINDOW_LEN   = 2'd0,
      CSR_SAMPLE_PER   = 2'd1,
      CSR_INV_PER      = 2'd2,
      CSR_START_POS    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAW_MUL,
      ST_RAW_FIX,
      ST_DIV_SETUP,
      ST_DIV,
      ST_VEL_ACC,
      ST_POS_MUL,
      ST_POS_ACC,
      ST_OUT
   } state_type;

   // saturate a 49 bit signed sum to 48 bits
   function automatic logic signed [ACC_W-1:0] sat49_to_48(input logic signed [ACC_W:0] v);
      logic signed [ACC_W-1:0] r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   // saturate a 48 bit signed accumulator to 32 bits
   function automatic logic signed [DATA_W-1:0] sat48_to_32(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      logic                     fits;
      fits = (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){1'b0}}) ||
             (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){1'b1}});
      if (fits) begin
         r = v[DATA_W-1:0];
      end else begin
         r = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: rtl/moving_average_velocity_profiler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_velocity_profiler_top: boxcar trajectory smoothing, Q16.16
// one item per tick, smoothed velocity and integrated position per tick
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per tick; tdata carries the sample position, tuser
//   carries op (rest tick or position sample) and first (restart, tick zero)
//   rsp channel: one item per accepted req item, tdata carries smoothed
//   velocity (low word) and profiled position (high word), both saturated
//   csr port: write-only, csr_addr selects window length, sample period,
//   inverse period or start position; write only while the block is idle
// sequencing
//   a tick-zero item goes from idle straight to the output state
//   any other item runs raw multiply and raw fix (first pass of the shared
//   32x32 multiplier), divider setup, the 32 step restoring divider that
//   forms raw/i or (raw - old raw)/window, velocity accumulate, position
//   multiply (second pass), position accumulate and output; req_tready is
//   high only in idle, so no item is taken before the last leaves output
// reset and stalls
//   reset loads the csr defaults and acts as a tick zero at position zero
//   the result sits in an output register; a new item can be accepted while
//   it waits, and the sequencer holds its next result until the slot frees
// ----------------------------------------------------------------------------
module moving_average_velocity_profiler_top (
   input  logic                           clock,
   input  logic                           reset,
   // request item
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mavp_pkg::DATA_W-1:0]    req_tdata,   // [31:0] sample_position
   input  logic [1:0]                     req_tuser,   // [0] op, [1] first
   // result item
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [2*mavp_pkg::DATA_W-1:0]  rsp_tdata,   // [31:0] smooth_velocity,
                                                       // [63:32] profiled_position
   // configuration
   input  logic                           csr_we,
   input  logic [mavp_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [mavp_pkg::DATA_W-1:0]    csr_wdata
);

   import mavp_pkg::*;

   // control and configuration registers
   state_type                  state_ff, state_in;
   logic [WIN_W-1:0]           win_len_ff;
   logic [DATA_W-1:0]          period_ff;
   logic [DATA_W-1:0]          inv_period_ff;
   logic [DATA_W-1:0]          start_pos_ff;

   // trajectory state
   logic signed [DATA_W-1:0]   prev_sample_ff;
   logic                       have_prev_ff;
   logic [TICK_W-1:0]          tick_index_ff;
   logic signed [ACC_W-1:0]    vel_acc_ff;
   logic signed [ACC_W-1:0]    pos_acc_ff;
   logic [HIST_AW-1:0]         hist_ptr_ff;

   // per item working registers
   logic [TICK_W-1:0]          tick_i_ff;      // tick index of this item
   logic [TICK_W-1:0]          win_eff_ff;     // clamped window length
   logic [DATA_W-1:0]          diff_mag_ff;
   logic                       diff_neg_ff;
   logic [2*DATA_W-1:0]        prod_ff;
   logic signed [DATA_W-1:0]   raw_ff;
   logic [DATA_W-1:0]          quot_ff;
   logic [TICK_W-1:0]          rem_ff;
   logic [TICK_W-1:0]          divisor_ff;
   logic                       quot_neg_ff;
   logic [DIV_CNT_W-1:0]       div_cnt_ff;
   logic                       vel_neg_ff;

   // output register
   logic                       rsp_valid_ff;
   logic [2*DATA_W-1:0]        rsp_data_ff;

   // sequencer outputs
   logic                       accept;
   logic                       mul_vel_sel;
   logic                       hist_we;
   logic                       load_rsp;

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = req_tuser[1] ? ST_OUT : ST_RAW_MUL;
            end
         end
         ST_RAW_MUL:   state_in = ST_RAW_FIX;
         ST_RAW_FIX:   state_in = ST_DIV_SETUP;
         ST_DIV_SETUP: state_in = ST_DIV;
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
               state_in = ST_VEL_ACC;
            end
         end
         ST_VEL_ACC:   state_in = ST_POS_MUL;
         ST_POS_MUL:   state_in = ST_POS_ACC;
         ST_POS_ACC:   state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_tready  = 1'b0;
      mul_vel_sel = 1'b0;
      hist_we     = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_tready  = 1'b1;
         ST_POS_MUL: mul_vel_sel = 1'b1;
         ST_VEL_ACC: hist_we     = 1'b1;
         ST_OUT:     load_rsp    = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // datapath helpers
   // ------------------------------------------------------------------
   logic signed [DATA_W:0]     pos_diff;
   logic [TICK_W-1:0]          win_eff;
   logic [TICK_W-1:0]          tick_next;
   logic [HIST_AW-1:0]         hist_rd_idx;
   logic [DATA_W-1:0]          hist_rd_data;
   logic [DATA_W-1:0]          mul_a, mul_b;
   logic [ACC_W-1:0]           prod_shift;
   logic signed [DATA_W-1:0]   raw_val;
   logic                       startup;
   logic signed [DATA_W:0]     div_num;
   logic [DATA_W-1:0]          div_mag;
   logic [TICK_W:0]            rem_shift;
   logic                       rem_ge;
   logic signed [DATA_W:0]     quot_signed;
   logic signed [DATA_W-1:0]   vel_sat;
   logic [DATA_W-1:0]          vel_mag;
   logic signed [ACC_W-1:0]    pos_step;

   assign pos_diff = $signed({req_tdata[DATA_W-1], req_tdata})
                   - $signed({prev_sample_ff[DATA_W-1], prev_sample_ff});

   // window 0 acts as 1, anything above the history depth is clamped
   always_comb begin
      if (32'(win_len_ff) == 32'd0) begin
         win_eff = TICK_W'(1);
      end else if (32'(win_len_ff) > 32'(MAX_WINDOW)) begin
         win_eff = TICK_W'(MAX_WINDOW);
      end else begin
         win_eff = TICK_W'(win_len_ff);
      end
   end

   assign tick_next = tick_index_ff + TICK_W'(1);

   // history entry written window ticks ago, pointer wraps with the depth
   assign hist_rd_idx = hist_ptr_ff - win_eff_ff[HIST_AW-1:0];

   mavp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_WINDOW)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_ptr_ff),
      .wr_data (raw_ff),
      .rd_addr (hist_rd_idx),
      .rd_data (hist_rd_data)
   );

   // shared multiplier: raw velocity first, position step later
   assign mul_a = mul_vel_sel ? vel_mag   : diff_mag_ff;
   assign mul_b = mul_vel_sel ? period_ff : inv_period_ff;

   assign prod_shift = prod_ff[2*DATA_W-1:16];

   // raw velocity: magnitude product >> 16, sign back on, saturate to 32 bits
   always_comb begin
      if (!diff_neg_ff) begin
         if (|prod_shift[ACC_W-1:DATA_W-1]) begin
            raw_val = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            raw_val = prod_shift[DATA_W-1:0];
         end
      end else begin
         if ((|prod_shift[ACC_W-1:DATA_W]) ||
             (prod_shift[DATA_W-1] && (|prod_shift[DATA_W-2:0]))) begin
            raw_val = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            raw_val = -prod_shift[DATA_W-1:0];
         end
      end
   end

   assign startup = tick_i_ff <= win_eff_ff;
   assign div_num = startup ? $signed({raw_ff[DATA_W-1], raw_ff})
                            : $signed({raw_ff[DATA_W-1], raw_ff})
                              - $signed({hist_rd_data[DATA_W-1], hist_rd_data});
   // |raw - old raw| stays below 2^32
   always_comb begin
      logic signed [DATA_W:0] neg_num;
      neg_num = -div_num;
      div_mag = div_num[DATA_W] ? neg_num[DATA_W-1:0] : div_num[DATA_W-1:0];
   end

   // one restoring division step
   assign rem_shift = {rem_ff, quot_ff[DATA_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, divisor_ff};

   assign quot_signed = quot_neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});

   assign vel_sat = sat48_to_32(vel_acc_ff);
   assign vel_mag = vel_sat[DATA_W-1] ? DATA_W'(-vel_sat) : DATA_W'(vel_sat);

   // product below 2^63, so the shifted step fits 48 bit signed
   assign pos_step = vel_neg_ff ? -$signed(prod_shift) : $signed(prod_shift);

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         win_len_ff     <= WIN_W'(1);
         period_ff      <= DATA_W'(66);
         inv_period_ff  <= DATA_W'(65536000);
         start_pos_ff   <= '0;
         prev_sample_ff <= '0;
         have_prev_ff   <= 1'b0;
         tick_index_ff  <= '0;
         vel_acc_ff     <= '0;
         pos_acc_ff     <= '0;
         hist_ptr_ff    <= '0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_WINDOW_LEN: win_len_ff    <= csr_wdata[WIN_W-1:0];
               CSR_SAMPLE_PER: period_ff     <= csr_wdata;
               CSR_INV_PER:    inv_period_ff <= csr_wdata;
               CSR_START_POS:  start_pos_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (accept) begin
            if (req_tuser[0]) begin
               prev_sample_ff <= req_tdata;
            end
            if (req_tuser[1]) begin
               // tick zero of a new trajectory
               have_prev_ff  <= req_tuser[0];
               tick_index_ff <= '0;
               vel_acc_ff    <= '0;
               pos_acc_ff    <= ACC_W'($signed(start_pos_ff));
            end else if (req_tuser[0]) begin
               have_prev_ff <= 1'b1;
            end
         end

         if (state_ff == ST_DIV_SETUP) begin
            div_cnt_ff <= '0;
         end else if (state_ff == ST_DIV) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end

         if (state_ff == ST_VEL_ACC) begin
            vel_acc_ff <= sat49_to_48($signed({vel_acc_ff[ACC_W-1], vel_acc_ff})
                                      + (ACC_W+1)'(quot_signed));
            hist_ptr_ff <= (32'(hist_ptr_ff) == 32'(MAX_WINDOW - 1))
                           ? '0 : hist_ptr_ff + HIST_AW'(1);
            tick_index_ff <= (32'(tick_i_ff) > 32'(MAX_WINDOW + 1))
                             ? TICK_W'(MAX_WINDOW + 1) : tick_i_ff;
         end

         if (state_ff == ST_POS_ACC) begin
            pos_acc_ff <= sat49_to_48($signed({pos_acc_ff[ACC_W-1], pos_acc_ff})
                                      + $signed({pos_step[ACC_W-1], pos_step}));
         end

         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         tick_i_ff   <= tick_next;
         win_eff_ff  <= win_eff;
         // first sample of a trajectory has zero raw velocity
         diff_neg_ff <= pos_diff[DATA_W] && req_tuser[0] && have_prev_ff;
         if (req_tuser[0] && have_prev_ff) begin
            diff_mag_ff <= pos_diff[DATA_W] ? DATA_W'(-pos_diff) : pos_diff[DATA_W-1:0];
         end else begin
            diff_mag_ff <= '0;
         end
      end

      if (state_ff == ST_RAW_MUL || state_ff == ST_POS_MUL) begin
         prod_ff <= (2*DATA_W)'(mul_a) * (2*DATA_W)'(mul_b);
      end

      if (state_ff == ST_RAW_FIX) begin
         raw_ff <= raw_val;
      end

      if (state_ff == ST_DIV_SETUP) begin
         quot_ff     <= div_mag;
         quot_neg_ff <= div_num[DATA_W];
         rem_ff      <= '0;
         divisor_ff  <= startup ? tick_i_ff : win_eff_ff;
      end else if (state_ff == ST_DIV) begin
         rem_ff  <= rem_ge ? TICK_W'(rem_shift - {1'b0, divisor_ff})
                           : rem_shift[TICK_W-1:0];
         quot_ff <= {quot_ff[DATA_W-2:0], rem_ge};
      end

      if (state_ff == ST_POS_MUL) begin
         vel_neg_ff <= vel_sat[DATA_W-1];
      end

      if (load_rsp) begin
         rsp_data_ff <= {sat48_to_32(pos_acc_ff), sat48_to_32(vel_acc_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sequencer took a new item right after accepting one");

   a_tick_bound : assert property (@(posedge clock) disable iff (reset)
      32'(tick_index_ff) <= 32'(MAX_WINDOW + 1))
      else $error("tick index ran past its clamp");

   a_divisor_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (divisor_ff != '0 && 32'(divisor_ff) <= 32'(MAX_WINDOW)))
      else $error("divisor out of range during division");

   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (rem_ff < divisor_ff))
      else $error("division remainder not below divisor");

endmodule

// File: rtl/mavp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavp_ram: generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mavp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
